// ===== sv/satc_pkg.sv =====
// Shared constants and types of the set-associative cache tag controller.
package satc_pkg;

    localparam int SETS      = 1024;
    localparam int WAYS      = 16;
    localparam int ADDR_BITS = 31;
    localparam int SET_W     = $clog2(SETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int CNT_W     = WAY_W + 1;
    localparam int LFSR_W    = 16;
    localparam int DIV_CNT_W = $clog2(LFSR_W);

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS  = 2'd0,
        CFG_INDEX_BITS   = 2'd1,
        CFG_WAYS_IN_USE  = 2'd2,
        CFG_REPLACE_MODE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_RANDOM    = 2'd0,
        MODE_LRU       = 2'd1,
        MODE_RAND_NMRU = 2'd2,
        MODE_LRU_ALT   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0]            dirty;
        logic [WAYS-1:0][WAY_W-1:0] rank;
    } t_row;

endpackage

// ===== sv/satc_req_if.sv =====
// Access request channel: valid/ready handshake with access kind and address.
interface satc_req_if import satc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output func, output address, input ready);
    modport sink   (input valid, input func, input address, output ready);
endinterface

// ===== sv/satc_rsp_if.sv =====
// Access response channel: valid/ready handshake with hit, eviction and way.
interface satc_rsp_if import satc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             hit;
    logic             replaced;
    logic             dirty_evicted;
    logic [WAY_W-1:0] way;

    modport source (output valid, output hit, output replaced, output dirty_evicted,
                    output way, input ready);
    modport sink   (input valid, input hit, input replaced, input dirty_evicted,
                    input way, output ready);
endinterface

// ===== sv/set_assoc_cache_tag_controller.sv =====
// Top level of the set-associative cache tag controller with scan sequencer.
//
//   channel   dir   handshake        payload
//   i_req     in    valid / ready    func, address
//   o_rsp     out   valid / ready    hit, replaced, dirty_evicted, way
//   i_cfg     in    i_cfg_we         i_cfg_idx, i_cfg_data
//
// One access steps through a state-row read, one tag read and rank count per
// way in use through the shared scan unit, a last-compare state, a decide
// state and an update state. A random eviction adds a pass through the serial
// remainder unit. After reset a clearing pass zeroes all 1024 state rows;
// i_req.ready stays low meanwhile. A stalled response holds in its output
// register; the next request is taken and runs up to its update.
module set_assoc_cache_tag_controller import satc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    satc_req_if.sink              i_req,
    satc_rsp_if.source            o_rsp
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_ROW    = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_LAST   = 8'b0001_0000,
        S_DECIDE = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_UPD    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [4:0]  r_offset_bits;
    logic [3:0]  r_index_bits;
    logic [4:0]  r_ways_in_use;
    logic [1:0]  r_replace_mode;

    logic [SET_W-1:0]     r_clr;
    logic [WAY_W-1:0]     r_cnt;
    logic [SET_W-1:0]     r_set;
    logic [ADDR_BITS-1:0] r_block;
    logic                 r_func;
    logic                 r_cmp_vld;
    logic [WAY_W-1:0]     r_cmp_way;
    logic                 r_hit;
    logic [WAY_W-1:0]     r_hitway;
    logic [WAYS-1:0][WAY_W-1:0] r_pos;
    logic [WAY_W-1:0]     r_k;
    logic [LFSR_W-1:0]    r_lfsr;
    logic [LFSR_W-1:0]    r_dvd;
    logic [CNT_W-1:0]     r_dsr;
    logic [CNT_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_dcnt;

    logic                 r_ovalid;
    logic                 r_o_hit;
    logic                 r_o_replaced;
    logic                 r_o_dirty;
    logic [WAY_W-1:0]     r_o_way;

    t_row                 row_mem [SETS];
    logic [ADDR_BITS-1:0] tag_mem [SETS*WAYS];
    t_row                 r_row;
    logic [ADDR_BITS-1:0] r_tag;

    logic                 req_xfer;
    logic                 out_free;
    logic [ADDR_BITS-1:0] n_block;
    logic [SET_W-1:0]     n_set;
    logic [SET_W-1:0]     idx_mask;
    logic [CNT_W-1:0]     w;
    logic [CNT_W-1:0]     w_m1;
    t_mode                mode;
    logic [WAYS-1:0]      wmask;
    logic [WAYS-1:0]      vmask;
    logic [CNT_W-1:0]     n_valid;
    logic [CNT_W-1:0]     valid_m1;
    logic [WAY_W-1:0]     freeway;
    logic                 full;
    logic [CNT_W-1:0]     scan_pos;
    logic                 cmp_match;
    logic                 need_rand;
    logic [LFSR_W-1:0]    lfsr_next;
    logic [CNT_W:0]       div_t;
    logic [CNT_W:0]       div_r;
    logic [WAY_W-1:0]     victim;
    logic [WAY_W-1:0]     target;
    logic [WAY_W-1:0]     kk;
    logic                 evict;
    logic [WAYS-1:0][WAY_W-1:0] new_pos;
    t_row                 new_row;
    logic                 row_we;
    logic [SET_W-1:0]     row_wa;
    t_row                 row_wd;

    assign req_xfer    = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.hit           = r_o_hit;
    assign o_rsp.replaced      = r_o_replaced;
    assign o_rsp.dirty_evicted = r_o_dirty;
    assign o_rsp.way           = r_o_way;

    always_comb begin
        n_block = i_req.address >> r_offset_bits;
        for (int i = 0; i < SET_W; i++) begin
            idx_mask[i] = (CNT_W'(i) < CNT_W'(r_index_bits));
        end
        n_set = n_block[SET_W-1:0] & idx_mask;
    end

    always_comb begin
        if (r_ways_in_use == '0) begin
            w = CNT_W'(1);
        end else if (r_ways_in_use > CNT_W'(WAYS)) begin
            w = CNT_W'(WAYS);
        end else begin
            w = r_ways_in_use;
        end
        w_m1 = w - CNT_W'(1);
        mode = (t_mode'(r_replace_mode) == MODE_LRU_ALT) ? MODE_LRU : t_mode'(r_replace_mode);
    end

    always_comb begin
        n_valid = '0;
        freeway = '0;
        for (int y = WAYS - 1; y >= 0; y--) begin
            wmask[y] = (CNT_W'(y) < w);
            vmask[y] = wmask[y] && r_row.valid[y];
            if (wmask[y] && !r_row.valid[y]) begin
                freeway = WAY_W'(y);
            end
        end
        for (int y = 0; y < WAYS; y++) begin
            n_valid = n_valid + CNT_W'(vmask[y]);
        end
        valid_m1 = n_valid - CNT_W'(1);
        full = (n_valid == w);
    end

    // rank position of the way under scan among the valid ways in use
    always_comb begin
        scan_pos = '0;
        for (int y = 0; y < WAYS; y++) begin
            if (vmask[y] && (WAY_W'(y) != r_cnt) &&
                ((r_row.rank[y] < r_row.rank[r_cnt]) ||
                 ((r_row.rank[y] == r_row.rank[r_cnt]) && (WAY_W'(y) < r_cnt)))) begin
                scan_pos = scan_pos + CNT_W'(1);
            end
        end
        if (!r_row.valid[r_cnt]) begin
            scan_pos = '0;
        end
    end

    assign cmp_match = r_cmp_vld && r_row.valid[r_cmp_way] && (r_tag == r_block);

    assign need_rand = !r_hit && full &&
                       ((mode == MODE_RANDOM) || ((mode == MODE_RAND_NMRU) && (w > CNT_W'(1))));
    assign lfsr_next = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[LFSR_W-1:1]};

    always_comb begin
        div_t = {r_rem, r_dvd[LFSR_W-1]};
        div_r = (div_t >= {1'b0, r_dsr}) ? (div_t - {1'b0, r_dsr}) : div_t;
    end

    always_comb begin
        victim = '0;
        for (int y = 0; y < WAYS; y++) begin
            if (vmask[y] && (r_pos[y] == r_k)) begin
                victim = WAY_W'(y);
            end
        end
        evict  = !r_hit && full;
        target = r_hit ? r_hitway : (full ? victim : freeway);
        kk     = r_pos[target];
        for (int y = 0; y < WAYS; y++) begin
            new_pos[y] = r_pos[y];
            if ((r_hit || evict) && (mode != MODE_RANDOM) && vmask[y] && (r_pos[y] > kk)) begin
                new_pos[y] = r_pos[y] - WAY_W'(1);
            end
        end
        if (r_hit || evict) begin
            if (mode != MODE_RANDOM) begin
                new_pos[target] = valid_m1[WAY_W-1:0];
            end
        end else begin
            new_pos[target] = n_valid[WAY_W-1:0];
        end

        new_row = r_row;
        if (r_hit) begin
            if (r_func) begin
                new_row.dirty[target] = 1'b1;
            end
        end else begin
            new_row.valid[target] = 1'b1;
            new_row.dirty[target] = r_func;
        end
        for (int y = 0; y < WAYS; y++) begin
            if (wmask[y] && new_row.valid[y]) begin
                new_row.rank[y] = new_pos[y];
            end
        end
    end

    always_comb begin
        row_we = 1'b0;
        row_wa = r_set;
        row_wd = new_row;
        if (r_state == S_CLEAR) begin
            row_we = 1'b1;
            row_wa = r_clr;
            row_wd = '0;
        end else if ((r_state == S_UPD) && out_free) begin
            row_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == SET_W'(SETS - 1)) n_state = S_IDLE;
            S_IDLE:   if (req_xfer) n_state = S_ROW;
            S_ROW:    n_state = S_SCAN;
            S_SCAN:   if (r_cnt == w_m1[WAY_W-1:0]) n_state = S_LAST;
            S_LAST:   n_state = S_DECIDE;
            S_DECIDE: n_state = need_rand ? S_DIV : S_UPD;
            S_DIV:    if (r_dcnt == DIV_CNT_W'(LFSR_W - 1)) n_state = S_UPD;
            S_UPD:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_wa] <= row_wd;
        end
        if (r_state == S_ROW) begin
            r_row <= row_mem[r_set];
        end
        if ((r_state == S_UPD) && out_free && !r_hit) begin
            tag_mem[{r_set, target}] <= r_block;
        end
        if (r_state == S_SCAN) begin
            r_tag <= tag_mem[{r_set, r_cnt}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_cnt          <= '0;
            r_cmp_vld      <= 1'b0;
            r_hit          <= 1'b0;
            r_dcnt         <= '0;
            r_lfsr         <= LFSR_SEED;
            r_ovalid       <= 1'b0;
            r_offset_bits  <= 5'd6;
            r_index_bits   <= 4'd6;
            r_ways_in_use  <= 5'd4;
            r_replace_mode <= MODE_LRU;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_SCAN);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + SET_W'(1);
            end
            if (r_state == S_ROW) begin
                r_cnt <= '0;
                r_hit <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + WAY_W'(1);
            end
            if (cmp_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if ((r_state == S_DECIDE) && need_rand) begin
                r_lfsr <= lfsr_next;
                r_dcnt <= '0;
            end else if (r_state == S_DIV) begin
                r_dcnt <= r_dcnt + DIV_CNT_W'(1);
            end
            if ((r_state == S_UPD) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_OFFSET_BITS:  r_offset_bits  <= i_cfg_data[4:0];
                    CFG_INDEX_BITS:   r_index_bits   <= i_cfg_data[3:0];
                    CFG_WAYS_IN_USE:  r_ways_in_use  <= i_cfg_data[4:0];
                    CFG_REPLACE_MODE: r_replace_mode <= i_cfg_data[1:0];
                    default:          r_replace_mode <= r_replace_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_block <= n_block;
            r_set   <= n_set;
            r_func  <= i_req.func;
        end
        if (r_state == S_SCAN) begin
            r_pos[r_cnt] <= scan_pos[WAY_W-1:0];
            r_cmp_way    <= r_cnt;
        end
        if (cmp_match && !r_hit) begin
            r_hitway <= r_cmp_way;
        end
        if (r_state == S_DECIDE) begin
            r_k   <= '0;
            r_dvd <= lfsr_next;
            r_rem <= '0;
            r_dsr <= (mode == MODE_RANDOM) ? w : w_m1;
        end else if (r_state == S_DIV) begin
            r_dvd <= {r_dvd[LFSR_W-2:0], 1'b0};
            r_rem <= div_r[CNT_W-1:0];
            r_k   <= div_r[WAY_W-1:0];
        end
        if ((r_state == S_UPD) && out_free) begin
            r_o_hit      <= r_hit;
            r_o_replaced <= evict;
            r_o_dirty    <= evict && r_row.dirty[target];
            r_o_way      <= target;
        end
    end

endmodule

// ===== verif/set_assoc_cache_tag_controller_checker.sv =====
// Checker for the cache tag controller: mirrors line state and scores responses.
module set_assoc_cache_tag_controller_checker import satc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    satc_req_if                   i_req,
    satc_rsp_if                   i_rsp,
    output int                    o_fail_count,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             hit;
        logic             replaced;
        logic             dirty_evicted;
        logic [WAY_W-1:0] way;
    } t_outcome;

    logic [ADDR_BITS-1:0] line_block [SETS*WAYS];
    bit                   line_valid [SETS*WAYS];
    bit                   line_dirty [SETS*WAYS];
    bit   [WAY_W-1:0]     line_rank  [SETS*WAYS];
    logic [LFSR_W-1:0]    victim_lfsr;
    logic [4:0]           offset_bits;
    logic [3:0]           index_bits;
    logic [4:0]           ways_in_use;
    t_mode                repl_mode;
    t_outcome             awaited_outcomes [$];
    int                   mismatches = 0;

    function automatic int unsigned draw_position(int unsigned span);
        logic fb;
        fb = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
        victim_lfsr = {fb, victim_lfsr[LFSR_W-1:1]};
        return victim_lfsr % span;
    endfunction

    function automatic t_outcome cache_lookup(logic is_write, logic [ADDR_BITS-1:0] addr);
        logic [ADDR_BITS-1:0] blk;
        logic [63:0]          set_field;
        int unsigned          base, w, n, k, tgt, x, y;
        int                   hit_way, free_way;
        int unsigned          pos [WAYS];
        t_mode                mode;
        t_outcome             res;
        blk = addr >> offset_bits;
        set_field = 64'(blk) & ((64'd1 << index_bits) - 64'd1);
        base = int'(set_field % SETS) * WAYS;
        w = (ways_in_use == 0) ? 1 : (ways_in_use > WAYS) ? WAYS : ways_in_use;
        mode = (repl_mode == MODE_LRU_ALT) ? MODE_LRU : repl_mode;
        n = 0;
        hit_way = -1;
        free_way = -1;
        tgt = 0;
        res = '0;
        for (x = 0; x < WAYS; x++) pos[x] = 0;

        for (x = 0; x < w; x++) begin
            if (line_valid[base+x]) begin
                n++;
                if (hit_way < 0 && line_block[base+x] == blk) hit_way = x;
            end else if (free_way < 0) begin
                free_way = x;
            end
        end
        for (x = 0; x < w; x++) begin
            if (!line_valid[base+x]) continue;
            for (y = 0; y < w; y++) begin
                if (y == x || !line_valid[base+y]) continue;
                if (line_rank[base+y] < line_rank[base+x] ||
                    (line_rank[base+y] == line_rank[base+x] && y < x))
                    pos[x]++;
            end
        end

        if (hit_way >= 0) begin
            res.hit = 1'b1;
            tgt = hit_way;
            if (is_write) line_dirty[base+tgt] = 1'b1;
            if (mode != MODE_RANDOM) begin
                k = pos[tgt];
                for (y = 0; y < w; y++)
                    if (line_valid[base+y] && pos[y] > k) pos[y]--;
                pos[tgt] = n - 1;
            end
        end else begin
            if (n < w) begin
                tgt = free_way;
                pos[tgt] = n;
            end else begin
                if (mode == MODE_RANDOM) k = draw_position(w);
                else if (mode == MODE_RAND_NMRU && w > 1) k = draw_position(w - 1);
                else k = 0;
                for (y = 0; y < w; y++)
                    if (line_valid[base+y] && pos[y] == k) tgt = y;
                res.replaced = 1'b1;
                res.dirty_evicted = line_dirty[base+tgt];
                if (mode != MODE_RANDOM) begin
                    for (y = 0; y < w; y++)
                        if (line_valid[base+y] && pos[y] > k) pos[y]--;
                    pos[tgt] = n - 1;
                end
            end
            line_block[base+tgt] = blk;
            line_valid[base+tgt] = 1'b1;
            line_dirty[base+tgt] = is_write;
        end

        for (x = 0; x < w; x++)
            if (line_valid[base+x]) line_rank[base+x] = WAY_W'(pos[x]);
        res.way = WAY_W'(tgt);
        return res;
    endfunction

    always @(posedge i_clk) begin : score
        t_outcome seen, want;
        int       i;
        if (!i_rst_n) begin
            for (i = 0; i < SETS*WAYS; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_rank[i]  = '0;
            end
            victim_lfsr = LFSR_SEED;
            offset_bits = 5'd6;
            index_bits  = 4'd6;
            ways_in_use = 5'd4;
            repl_mode   = MODE_LRU;
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_OFFSET_BITS:  offset_bits = i_cfg_data;
                    CFG_INDEX_BITS:   index_bits  = i_cfg_data[3:0];
                    CFG_WAYS_IN_USE:  ways_in_use = i_cfg_data;
                    CFG_REPLACE_MODE: repl_mode   = t_mode'(i_cfg_data[1:0]);
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                seen.hit           = i_rsp.hit;
                seen.replaced      = i_rsp.replaced;
                seen.dirty_evicted = i_rsp.dirty_evicted;
                seen.way           = i_rsp.way;
                if (awaited_outcomes.size() == 0) begin
                    if (mismatches < 10)
                        $display({"%0t: response with no access outstanding: ",
                                  "hit %0b replaced %0b dirty %0b way %0d"},
                                 $realtime, seen.hit, seen.replaced, seen.dirty_evicted,
                                 seen.way);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (seen.hit !== want.hit || seen.replaced !== want.replaced ||
                        seen.dirty_evicted !== want.dirty_evicted || seen.way !== want.way) begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch: expected hit %0b replaced %0b ",
                                      "dirty %0b way %0d, got hit %0b replaced %0b ",
                                      "dirty %0b way %0d"},
                                     $realtime, want.hit, want.replaced, want.dirty_evicted,
                                     want.way, seen.hit, seen.replaced, seen.dirty_evicted,
                                     seen.way);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                awaited_outcomes.insert(awaited_outcomes.size(),
                                        cache_lookup(i_req.func, i_req.address));
        end
        o_fail_count  <= mismatches;
        o_outstanding <= awaited_outcomes.size();
    end

endmodule

// ===== verif/set_assoc_cache_tag_controller_test.sv =====
// Testbench top for the cache tag controller: clock, reset, configuration phases and access traffic.
module set_assoc_cache_tag_controller_test import satc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    cycle_count = 0;
    bit                    req_steady;
    bit                    rsp_steady;
    int unsigned           eff_offset;
    int unsigned           eff_index;
    int unsigned           eff_ways;

    satc_req_if req_ch ();
    satc_rsp_if rsp_ch ();

    set_assoc_cache_tag_controller dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    set_assoc_cache_tag_controller_checker mirror (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL set_assoc_cache_tag_controller");
            $finish;
        end
    end

    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [63:0] blk;
        int unsigned tag, set_no;
        if ($urandom_range(0, 4) == 0) return ADDR_BITS'($urandom);
        tag = $urandom_range(0, eff_ways + 2);
        set_no = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
        blk = (64'(tag) << eff_index) | (64'(set_no) & ((64'd1 << eff_index) - 64'd1));
        return ADDR_BITS'((blk << eff_offset) | (64'($urandom) & ((64'd1 << eff_offset) - 64'd1)));
    endfunction

    task automatic send_access(logic is_write, logic [ADDR_BITS-1:0] addr);
        int unsigned gap;
        gap = req_steady ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.func    <= is_write;
        req_ch.address <= addr;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic random_accesses(int unsigned count);
        repeat (count) send_access(1'($urandom), pick_address());
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic run_phase(int unsigned ob, int unsigned ib, int unsigned ways, t_mode mode,
                             int unsigned count);
        wait_idle();
        write_reg(CFG_OFFSET_BITS, CFG_DATA_W'(ob));
        write_reg(CFG_INDEX_BITS, {1'($urandom), 4'(ib)});
        write_reg(CFG_WAYS_IN_USE, CFG_DATA_W'(ways));
        write_reg(CFG_REPLACE_MODE, {3'($urandom), mode});
        cfg_we <= 1'b0;
        eff_offset = ob;
        eff_index  = ib;
        eff_ways   = (ways == 0) ? 1 : (ways > WAYS) ? WAYS : ways;
        req_steady = ($urandom_range(0, 2) == 0);
        rsp_steady = ($urandom_range(0, 2) == 0);
        random_accesses(count);
    endtask

    initial begin
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = rsp_steady ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
        end
    end

    initial begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_OFFSET_BITS;
        cfg_data       <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.func    <= 1'b0;
        req_ch.address <= '0;
        req_steady = 1'b0;
        rsp_steady = 1'b0;
        eff_offset = 6;
        eff_index  = 6;
        eff_ways   = 4;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // fill set 0, then evict dirty and clean lines in LRU order
        send_access(1'b0, 31'h0000_0000);
        send_access(1'b1, 31'h7FFF_FFFF);
        send_access(1'b0, 31'h7FFF_FFFF);
        send_access(1'b1, 31'h0000_1000);
        send_access(1'b1, 31'h0000_2000);
        send_access(1'b0, 31'h0000_3000);
        send_access(1'b0, 31'h0000_0010);
        send_access(1'b1, 31'h0000_4000);
        send_access(1'b0, 31'h0000_5000);
        send_access(1'b0, 31'h0000_6000);
        send_access(1'b1, 31'h0000_003F);
        send_access(1'b0, 31'h0000_7000);
        send_access(1'b1, 31'h7FFF_F03F);
        send_access(1'b0, 31'h0000_0040);
        send_access(1'b1, 31'h0000_4020);
        send_access(1'b0, 31'h5555_5555);
        random_accesses(100);

        run_phase(0, 0, 1, MODE_RANDOM, 112);
        run_phase(16, 10, 16, MODE_LRU, 112);
        run_phase(4, 2, 16, MODE_RAND_NMRU, 112);
        run_phase(31, 15, 31, MODE_LRU_ALT, 40);
        run_phase(0, 3, 0, MODE_RAND_NMRU, 112);
        run_phase(8, 1, 3, MODE_RANDOM, 112);
        run_phase(2, 10, 8, MODE_RAND_NMRU, 112);
        run_phase(20, 13, 17, MODE_LRU, 112);
        run_phase(5, 0, 2, MODE_RAND_NMRU, 112);
        run_phase(3, 5, 5, MODE_RANDOM, 112);
        run_phase(6, 4, 16, MODE_RANDOM, 112);

        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASS set_assoc_cache_tag_controller");
        else
            $display("FAIL set_assoc_cache_tag_controller");
        $finish;
    end

endmodule
